FILE: hdl/stcl_pkg.sv
// shared constants and types for the sorted table ceiling lookup
package stcl_pkg;

    // default table depth
    localparam int TABLE_DEPTH_DEF = 64;

    // field widths
    localparam int WORD_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DISCARD = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    // sequencer commands to the search unit
    typedef struct packed {
        logic start;   // load bounds and compare mode
        logic step;    // apply one compare and halve the range
        logic upper;   // at start: 1 finds first entry above key, 0 first not below
    } search_ctrl_t;

endpackage

FILE: hdl/stcl_req_if.sv
// request channel: request type and value word
interface stcl_req_if;
    logic                                valid;
    logic                                ready;
    logic [stcl_pkg::REQ_W-1:0]          req_type;
    logic signed [stcl_pkg::WORD_W-1:0]  item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

FILE: hdl/stcl_res_if.sv
// result channel: status and chosen size word
interface stcl_res_if;
    logic                                valid;
    logic                                ready;
    logic [stcl_pkg::STATUS_W-1:0]       status;
    logic signed [stcl_pkg::WORD_W-1:0]  chosen_size;

    modport source (output valid, output status, output chosen_size, input ready);
    modport sink   (input valid, input status, input chosen_size, output ready);
endinterface

FILE: hdl/sorted_table_ceiling_lookup_core.sv
// top level: sorted size table with insert, clear and ceiling query
//
//  channel | modport | handshake     | payload
//  --------+---------+---------------+---------------------------------
//  req     | sink    | valid / ready | req_type[1:0], item_value[31:0]
//  res     | source  | valid / ready | status[2:0], chosen_size[31:0]
//
// clear, unused code, full insert and empty query go straight to the result
// query: binary search over n stored entries, then a read of the found entry unless discarded
// insert: binary search, then the m entries above the insert point each move up by one
// every search probe and every move goes through the single table read port
// and waits for its registered data
// reset clears the control state and entry count; table words are undefined until written
// a finished word waits in the output register while the next request is taken
module sorted_table_ceiling_lookup_core #(
    parameter int TABLE_DEPTH = stcl_pkg::TABLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    stcl_req_if.sink   req,
    stcl_res_if.source res
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SRCH_RD  = 7'b0000010,
        S_SRCH_CMP = 7'b0000100,
        S_FETCH    = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_RESULT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [CNT_W-1:0]                   idx_reg;
    logic [CNT_W-1:0]                   idx_next;
    logic [CNT_W-1:0]                   idx_dec;
    logic                               is_ins_reg;
    logic                               is_ins_next;
    logic signed [stcl_pkg::WORD_W-1:0] val_reg;
    logic [stcl_pkg::STATUS_W-1:0]      res_status_reg;
    logic [stcl_pkg::STATUS_W-1:0]      res_status_next;
    logic signed [stcl_pkg::WORD_W-1:0] res_size_reg;
    logic signed [stcl_pkg::WORD_W-1:0] res_size_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [stcl_pkg::STATUS_W-1:0]      out_status_reg;
    logic signed [stcl_pkg::WORD_W-1:0] out_size_reg;
    logic                               out_load;
    logic                               req_take;

    logic                               ram_we;
    logic [ADDR_W-1:0]                  ram_waddr;
    logic signed [stcl_pkg::WORD_W-1:0] ram_wdata;
    logic                               ram_re;
    logic [ADDR_W-1:0]                  ram_raddr;
    logic signed [stcl_pkg::WORD_W-1:0] ram_rdata;

    stcl_pkg::search_ctrl_t             sctrl;
    logic                               s_busy;
    logic [CNT_W-1:0]                   s_mid;
    logic [CNT_W-1:0]                   s_lo;

    // table memory
    stcl_table_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared search unit
    stcl_search_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sctrl),
        .count (count_reg),
        .key   (val_reg),
        .rdata (ram_rdata),
        .busy  (s_busy),
        .mid   (s_mid),
        .lo    (s_lo)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign req_take        = req.valid && req.ready;
    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.chosen_size = out_size_reg;
    assign idx_dec         = idx_reg - CNT_W'(1);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        is_ins_next     = is_ins_reg;
        res_status_next = res_status_reg;
        res_size_next   = res_size_reg;
        out_load        = 1'b0;
        sctrl           = '0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[ADDR_W-1:0];
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = s_mid[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next = stcl_pkg::ST_DONE;
                    res_size_next   = '0;
                    state_next      = S_RESULT;
                    case (req.req_type)
                        stcl_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        stcl_pkg::REQ_INSERT:
                        begin
                            if (count_reg == DEPTH_CNT)
                            begin
                                res_status_next = stcl_pkg::ST_FULL;
                            end
                            else
                            begin
                                sctrl.start = 1'b1;
                                sctrl.upper = 1'b1;
                                is_ins_next = 1'b1;
                                state_next  = S_SRCH_RD;
                            end
                        end
                        stcl_pkg::REQ_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = stcl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                sctrl.start = 1'b1;
                                sctrl.upper = 1'b0;
                                is_ins_next = 1'b0;
                                state_next  = S_SRCH_RD;
                            end
                        end
                        default:
                        begin
                            res_status_next = stcl_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                if (s_busy)
                begin
                    ram_re     = 1'b1;
                    state_next = S_SRCH_CMP;
                end
                else if (is_ins_reg)
                begin
                    idx_next   = count_reg;
                    state_next = S_SHIFT_RD;
                end
                else if (s_lo == count_reg)
                begin
                    res_status_next = stcl_pkg::ST_DISCARD;
                    res_size_next   = '0;
                    state_next      = S_RESULT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = s_lo[ADDR_W-1:0];
                    state_next = S_FETCH;
                end
            end
            S_SRCH_CMP:
            begin
                sctrl.step = 1'b1;
                state_next = S_SRCH_RD;
            end
            S_FETCH:
            begin
                res_status_next = stcl_pkg::ST_FOUND;
                res_size_next   = ram_rdata;
                state_next      = S_RESULT;
            end
            S_SHIFT_RD:
            begin
                if (idx_reg > s_lo)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_dec[ADDR_W-1:0];
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    // drop the new value into the gap
                    ram_we          = 1'b1;
                    ram_waddr       = s_lo[ADDR_W-1:0];
                    ram_wdata       = val_reg;
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = stcl_pkg::ST_DONE;
                    res_size_next   = '0;
                    state_next      = S_RESULT;
                end
            end
            S_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[ADDR_W-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_dec;
                state_next = S_SHIFT_RD;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg && !res.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            is_ins_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            is_ins_reg    <= is_ins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            val_reg <= req.item_value;
        end
        res_status_reg <= res_status_next;
        res_size_reg   <= res_size_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_size_reg   <= res_size_reg;
        end
    end

    // entry count stays within the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above table depth");

    // search reads only stored entries
    a_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH_CMP) |-> (s_mid < count_reg))
        else $error("search probe outside stored entries");

    // insert into a full table leaves the count alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && req.req_type == stcl_pkg::REQ_INSERT && count_reg == DEPTH_CNT)
        |=> $stable(count_reg))
        else $error("full insert changed the entry count");

    // size word is zero unless a size was found
    a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != stcl_pkg::ST_FOUND) |-> (out_size_reg == '0))
        else $error("nonzero size with status other than found");

    // shift moves never run past the new slot
    a_shift_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_WR) |-> (idx_reg > s_lo))
        else $error("shift below insert point");

endmodule

FILE: hdl/stcl_table_ram.sv
// size table memory: one write port, one registered read port
module stcl_table_ram #(
    parameter int TABLE_DEPTH = stcl_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [ADDR_W-1:0]                  waddr,
    input  logic signed [stcl_pkg::WORD_W-1:0] wdata,
    input  logic                               re,
    input  logic [ADDR_W-1:0]                  raddr,
    output logic signed [stcl_pkg::WORD_W-1:0] rdata
);

    logic signed [stcl_pkg::WORD_W-1:0] mem [TABLE_DEPTH];
    logic signed [stcl_pkg::WORD_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/stcl_search_unit.sv
// binary search bounds and the shared signed compare
module stcl_search_unit #(
    parameter int TABLE_DEPTH = stcl_pkg::TABLE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  stcl_pkg::search_ctrl_t             ctrl,
    input  logic [CNT_W-1:0]                   count,
    input  logic signed [stcl_pkg::WORD_W-1:0] key,
    input  logic signed [stcl_pkg::WORD_W-1:0] rdata,
    output logic                               busy,
    output logic [CNT_W-1:0]                   mid,
    output logic [CNT_W-1:0]                   lo
);

    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] lo_next;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] hi_next;
    logic             upper_reg;
    logic             upper_next;
    logic             go_right;

    // midpoint of the open range
    assign mid  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign busy = (lo_reg < hi_reg);
    assign lo   = lo_reg;

    // shared compare: move right past entries below (or not above) the key
    assign go_right = upper_reg ? (rdata <= key) : (rdata < key);

    // bound update
    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        upper_next = upper_reg;
        if (ctrl.start)
        begin
            lo_next    = '0;
            hi_next    = count;
            upper_next = ctrl.upper;
        end
        else if (ctrl.step)
        begin
            if (go_right)
            begin
                lo_next = mid + CNT_W'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg    <= '0;
            hi_reg    <= '0;
            upper_reg <= 1'b0;
        end
        else
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            upper_reg <= upper_next;
        end
    end

endmodule

FILE: verif/stcl_ceiling_checker.sv
`timescale 1ns / 100ps
// scoreboard for the sorted table ceiling lookup: shadow table, expected words and compare
module stcl_ceiling_checker #(
    parameter int DEPTH = stcl_pkg::TABLE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    stcl_req_if  req,
    stcl_res_if  res,
    output int   fail_count,
    output int   pending,
    output int   done_seen,
    output int   found_seen,
    output int   discard_seen,
    output int   full_seen,
    output int   empty_seen
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [stcl_pkg::STATUS_W-1:0]      status;
        logic signed [stcl_pkg::WORD_W-1:0] chosen_size;
    } answer_t;

    // shadow copy of the sorted table
    logic signed [stcl_pkg::WORD_W-1:0] shadow_sizes [DEPTH];
    int                                 shadow_count;

    // answers waiting for their result word, oldest first
    answer_t expected_answers [$];

    // update the shadow table with one request and work out its answer
    function automatic answer_t table_answer(input logic [stcl_pkg::REQ_W-1:0] kind,
                                             input logic signed [stcl_pkg::WORD_W-1:0] value);
        answer_t ans;
        int      pos;
        ans.status      = stcl_pkg::ST_DONE;
        ans.chosen_size = '0;
        case (kind)
            stcl_pkg::REQ_CLEAR:
            begin
                shadow_count = 0;
            end
            stcl_pkg::REQ_INSERT:
            begin
                if (shadow_count >= DEPTH)
                begin
                    ans.status = stcl_pkg::ST_FULL;
                end
                else
                begin
                    // insert point lies after any equal entries
                    pos = 0;
                    while (pos < shadow_count && shadow_sizes[pos] <= value)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_sizes[i] = shadow_sizes[i-1];
                    shadow_sizes[pos] = value;
                    shadow_count++;
                end
            end
            stcl_pkg::REQ_QUERY:
            begin
                if (shadow_count == 0)
                begin
                    ans.status = stcl_pkg::ST_EMPTY;
                end
                else
                begin
                    // first entry not below the value
                    pos = 0;
                    while (pos < shadow_count && shadow_sizes[pos] < value)
                        pos++;
                    if (pos >= shadow_count)
                    begin
                        ans.status = stcl_pkg::ST_DISCARD;
                    end
                    else
                    begin
                        ans.status      = stcl_pkg::ST_FOUND;
                        ans.chosen_size = shadow_sizes[pos];
                    end
                end
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    task automatic flag_error(input string what, input answer_t want, input answer_t got);
        if (fail_count < REPORT_LIMIT)
            $display("%0t: %s: expected status %0d size %0d, got status %0d size %0d",
                     $realtime, what, want.status, $signed(want.chosen_size),
                     got.status, $signed(got.chosen_size));
        fail_count++;
    endtask

    // watch both channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            expected_answers.delete();
            fail_count   = 0;
            done_seen    = 0;
            found_seen   = 0;
            discard_seen = 0;
            full_seen    = 0;
            empty_seen   = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_answers.push_back(table_answer(req.req_type, req.item_value));
            if (res.valid && res.ready)
            begin
                got.status      = res.status;
                got.chosen_size = res.chosen_size;
                case (got.status)
                    stcl_pkg::ST_DONE:    done_seen++;
                    stcl_pkg::ST_FOUND:   found_seen++;
                    stcl_pkg::ST_DISCARD: discard_seen++;
                    stcl_pkg::ST_FULL:    full_seen++;
                    stcl_pkg::ST_EMPTY:   empty_seen++;
                    default:
                    begin
                    end
                endcase
                if (expected_answers.size() == 0)
                begin
                    flag_error("result word with nothing expected", '0, got);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.status !== want.status)
                        flag_error("status mismatch", want, got);
                    else if (got.chosen_size !== want.chosen_size)
                        flag_error("chosen size mismatch", want, got);
                end
            end
        end
        pending = expected_answers.size();
    end

endmodule

FILE: verif/tb_sorted_table_ceiling_lookup_core.sv
`timescale 1ns / 100ps
// testbench top for the sorted table ceiling lookup: clock, reset, stimulus and verdict
module tb_sorted_table_ceiling_lookup_core;

    localparam int TABLE_DEPTH  = stcl_pkg::TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;

    localparam logic [stcl_pkg::REQ_W-1:0]         REQ_UNUSED = 2'd3;
    localparam logic signed [stcl_pkg::WORD_W-1:0] SIZE_MIN   = 32'sh8000_0000;
    localparam logic signed [stcl_pkg::WORD_W-1:0] SIZE_MAX   = 32'sh7FFF_FFFF;

    logic clk;
    logic rst_n;

    stcl_req_if req_ch ();
    stcl_res_if res_ch ();

    int fail_count;
    int pending;
    int done_seen;
    int found_seen;
    int discard_seen;
    int full_seen;
    int empty_seen;

    // sender bookkeeping
    int  burst_left;
    int  n_clear;
    int  n_insert;
    int  n_query;
    int  n_unused;
    bit  hold_request;
    logic signed [stcl_pkg::WORD_W-1:0] stored_sizes [$];

    sorted_table_ceiling_lookup_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    stcl_ceiling_checker #(
        .DEPTH (TABLE_DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .res          (res_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .done_seen    (done_seen),
        .found_seen   (found_seen),
        .discard_seen (discard_seen),
        .full_seen    (full_seen),
        .empty_seen   (empty_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // offer one word, in bursts with random gaps, and wait for its accept
    task automatic push_word(input logic [stcl_pkg::REQ_W-1:0] kind,
                             input logic signed [stcl_pkg::WORD_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.item_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        burst_left--;
        case (kind)
            stcl_pkg::REQ_CLEAR:
            begin
                n_clear++;
                stored_sizes.delete();
            end
            stcl_pkg::REQ_INSERT:
            begin
                n_insert++;
                if (stored_sizes.size() < TABLE_DEPTH)
                    stored_sizes.push_back(value);
            end
            stcl_pkg::REQ_QUERY:  n_query++;
            default:              n_unused++;
        endcase
    endtask

    // stop offering until every expected word has come back
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic signed [stcl_pkg::WORD_W-1:0] any_stored();
        if (stored_sizes.size() == 0)
            return $urandom;
        return stored_sizes[$urandom_range(0, stored_sizes.size() - 1)];
    endfunction

    function automatic logic signed [stcl_pkg::WORD_W-1:0] extreme_size();
        case ($urandom_range(0, 3))
            0:       return SIZE_MIN;
            1:       return SIZE_MAX;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    // insert values: extremes, a narrow band for duplicates, repeats, full range
    function automatic logic signed [stcl_pkg::WORD_W-1:0] pick_insert_value();
        case ($urandom_range(0, 9))
            0:          return extreme_size();
            1, 2, 3, 4: return int'($urandom_range(0, 40)) - 20;
            5:          return any_stored();
            default:    return $urandom;
        endcase
    endfunction

    // query values: hits, neighbors of stored sizes, extremes, noise
    function automatic logic signed [stcl_pkg::WORD_W-1:0] pick_query_value();
        case ($urandom_range(0, 9))
            0:       return extreme_size();
            1, 2, 3: return any_stored();
            4:       return any_stored() + 1;
            5:       return any_stored() - 1;
            6, 7:    return int'($urandom_range(0, 40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    // receiver: changing stall pattern plus one long hold-off on request
    initial
    begin
        int mode;
        int segment_left;
        int hold_count;
        bit hold_served;
        res_ch.ready = 1'b0;
        mode         = 0;
        segment_left = 0;
        hold_served  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_served)
            begin
                res_ch.ready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_count++;
                end
                hold_served = 1'b1;
            end
            if (segment_left == 0)
            begin
                mode         = $urandom_range(0, 3);
                segment_left = $urandom_range(40, 160);
            end
            segment_left--;
            case (mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                default: res_ch.ready <= ~res_ch.ready;
            endcase
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // reset and stimulus
    initial
    begin
        int  sent;
        int  episode;
        int  fill_goal;
        int  inserts_done;
        int  roll;
        bit  hold_done;
        bit  pause_done;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = stcl_pkg::REQ_CLEAR;
        req_ch.item_value = '0;
        hold_request      = 1'b0;
        burst_left        = 0;
        n_clear           = 0;
        n_insert          = 0;
        n_query           = 0;
        n_unused          = 0;
        rst_n             = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, unused code, extremes, duplicates, ceiling edges
        push_word(stcl_pkg::REQ_QUERY, 5);
        push_word(REQ_UNUSED, -1);
        push_word(stcl_pkg::REQ_CLEAR, '0);
        push_word(stcl_pkg::REQ_INSERT, SIZE_MAX);
        push_word(stcl_pkg::REQ_INSERT, SIZE_MIN);
        push_word(stcl_pkg::REQ_INSERT, 0);
        push_word(stcl_pkg::REQ_INSERT, 0);
        push_word(stcl_pkg::REQ_INSERT, -1);
        push_word(stcl_pkg::REQ_QUERY, SIZE_MIN);
        push_word(stcl_pkg::REQ_QUERY, SIZE_MAX);
        push_word(stcl_pkg::REQ_QUERY, 1);
        push_word(stcl_pkg::REQ_QUERY, -2);
        push_word(stcl_pkg::REQ_QUERY, 0);
        push_word(stcl_pkg::REQ_QUERY, SIZE_MIN + 1);
        push_word(stcl_pkg::REQ_INSERT, SIZE_MAX);
        push_word(stcl_pkg::REQ_QUERY, SIZE_MAX);
        push_word(REQ_UNUSED, SIZE_MIN);
        push_word(stcl_pkg::REQ_QUERY, -1);
        push_word(stcl_pkg::REQ_CLEAR, '0);
        push_word(stcl_pkg::REQ_QUERY, 0);
        push_word(stcl_pkg::REQ_INSERT, 5);
        push_word(stcl_pkg::REQ_QUERY, 6);
        push_word(stcl_pkg::REQ_QUERY, 5);
        push_word(stcl_pkg::REQ_QUERY, 4);
        wait_for_drain();

        // random: episodes of an optional clear, a fill with queries mixed in, then queries
        sent       = 0;
        episode    = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (episode % 3 == 1 || $urandom_range(0, 5) == 0)
                fill_goal = TABLE_DEPTH + $urandom_range(1, 6);
            else
                fill_goal = $urandom_range(1, 20);
            if ($urandom_range(0, 4) != 0)
            begin
                push_word(stcl_pkg::REQ_CLEAR, $urandom);
                sent++;
            end
            inserts_done = 0;
            while (inserts_done < fill_goal && sent < RANDOM_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                begin
                    push_word(stcl_pkg::REQ_INSERT, pick_insert_value());
                    inserts_done++;
                    sent++;
                end
                else if (roll < 95)
                begin
                    push_word(stcl_pkg::REQ_QUERY, pick_query_value());
                    sent++;
                end
                else if (roll < 98)
                begin
                    push_word(REQ_UNUSED, $urandom);
                end
                else
                begin
                    // broken sequence: table emptied part way
                    push_word(stcl_pkg::REQ_CLEAR, $urandom);
                    sent++;
                end
                // long receiver hold-off while words keep coming
                if (!hold_done && sent >= 150)
                begin
                    hold_request = 1'b1;
                    hold_done    = 1'b1;
                end
                if (!pause_done && sent >= 300)
                begin
                    wait_for_drain();
                    pause_done = 1'b1;
                end
            end
            repeat ($urandom_range(3, 10))
            begin
                push_word(stcl_pkg::REQ_QUERY, pick_query_value());
                sent++;
            end
            episode++;
        end

        // let every result come back, then allow for the slowest insert
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d clears, %0d inserts, %0d queries, %0d unused codes",
                 n_clear, n_insert, n_query, n_unused);
        $display("results: %0d done, %0d found, %0d discard, %0d full, %0d empty",
                 done_seen, found_seen, discard_seen, full_seen, empty_seen);
        if (fail_count == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/stcl_pkg.sv
hdl/stcl_req_if.sv
hdl/stcl_res_if.sv
hdl/stcl_table_ram.sv
hdl/stcl_search_unit.sv
hdl/sorted_table_ceiling_lookup_core.sv
verif/stcl_ceiling_checker.sv
verif/tb_sorted_table_ceiling_lookup_core.sv
